### rtl/pbc_pkg.sv
// ============================================================================
// pbc_pkg: ping-pong buffer controller shared types and constants
// Transaction payloads, command codes and status group used by all modules but the bank memory.
// ============================================================================
package pbc_pkg;

    localparam int unsigned CFG_W  = 11;
    localparam int unsigned CNT_W  = 11;
    localparam int unsigned WORD_W = 32;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_POP   = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [WORD_W-1:0] push_data;
    } t_in_item;

    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] pop_data;
        logic              is_empty;
        logic              is_full;
        logic [CNT_W-1:0]  write_fill;
        logic [CNT_W-1:0]  read_left;
        logic              swap_pending;
    } t_out_item;

    typedef struct packed {
        logic             ok;
        logic             popped;
        logic             is_empty;
        logic             is_full;
        logic [CNT_W-1:0] write_fill;
        logic [CNT_W-1:0] read_left;
        logic             swap_pending;
    } t_stat;

endpackage

### rtl/ping_pong_buffer_controller_unit.sv
// ============================================================================
// ping_pong_buffer_controller_unit: two-bank ping-pong buffer
// Stages: input register, then bank control with registered memory read into
//   the result register.
// Throughput: 1 transaction per cycle; the whole pipeline holds on output stall.
// Reset: synchronous active-low; clears indices, bank select and swap state,
//   sets capacity to BANK_DEPTH. Bank contents are not cleared.
// ============================================================================
module ping_pong_buffer_controller_unit #(
    parameter int unsigned BANK_DEPTH = 1024,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [pbc_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  pbc_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output pbc_pkg::t_out_item        o_out_item
);

    localparam int unsigned MAW = $clog2(BANK_DEPTH) + 1;

    logic                r_in_valid;
    pbc_pkg::t_in_item   r_in_item;
    logic                r_s1_valid;
    pbc_pkg::t_stat      r_s1_stat;

    logic                en;
    logic                fire;
    pbc_pkg::t_stat      stat;
    logic                wr_en;
    logic [MAW-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                rd_en;
    logic [MAW-1:0]      rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    assign en          = !(r_s1_valid && i_out_stall);
    assign fire        = r_in_valid && en;
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_s1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_in_valid;
            r_s1_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_item <= i_in_item;
            r_s1_stat <= stat;
        end
    end

    pbc_ctrl #(
        .BANK_DEPTH (BANK_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_item     (r_in_item),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_stat     (stat)
    );

    pbc_bank_mem #(
        .ADDR_W (MAW),
        .DATA_W (DATA_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        o_out_item.ok             = r_s1_stat.ok;
        o_out_item.pop_data       = r_s1_stat.popped ? pbc_pkg::WORD_W'(rd_data) : '0;
        o_out_item.is_empty       = r_s1_stat.is_empty;
        o_out_item.is_full        = r_s1_stat.is_full;
        o_out_item.write_fill     = r_s1_stat.write_fill;
        o_out_item.read_left      = r_s1_stat.read_left;
        o_out_item.swap_pending   = r_s1_stat.swap_pending;
    end

`ifndef SYNTHESIS
    a_fire_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_s1_valid)
        else $error("accepted transaction did not reach the result register");

    a_pending_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_stat.swap_pending) |-> !r_s1_stat.is_empty)
        else $error("swap pending with an empty buffer");

    a_empty_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_stat.is_empty) |->
        (r_s1_stat.read_left == '0 && r_s1_stat.write_fill == '0))
        else $error("empty status with nonzero counts");
`endif

endmodule

### rtl/pbc_bank_mem.sv
// ============================================================================
// pbc_bank_mem: two-bank word storage
// One write port and one read port with registered read data.
// ============================================================================
module pbc_bank_mem #(
    parameter int unsigned ADDR_W = 11,
    parameter int unsigned DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/pbc_ctrl.sv
// ============================================================================
// pbc_ctrl: ping-pong bank control
// Holds bank select, indices, sizes and capacity; decodes one command per
// transaction, drives the bank memory ports and computes the status.
// ============================================================================
module pbc_ctrl #(
    parameter int unsigned BANK_DEPTH = 1024,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [pbc_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic                                   i_fire,
    input  pbc_pkg::t_in_item                      i_item,
    output logic                                   o_wr_en,
    output logic [$clog2(BANK_DEPTH):0]            o_wr_addr,
    output logic [DATA_WIDTH-1:0]                  o_wr_data,
    output logic                                   o_rd_en,
    output logic [$clog2(BANK_DEPTH):0]            o_rd_addr,
    output pbc_pkg::t_stat                         o_stat
);

    localparam int unsigned AW   = $clog2(BANK_DEPTH);
    localparam int unsigned CW   = $clog2(BANK_DEPTH + 1);

    logic          r_sel;
    logic [CW-1:0] r_wc;
    logic [CW-1:0] r_rpos;
    logic [CW-1:0] r_rsize;
    logic          r_swap_req;
    logic [CW-1:0] r_swap_size;
    logic [CW-1:0] r_cap;

    logic          n_sel;
    logic [CW-1:0] n_wc;
    logic [CW-1:0] n_rpos;
    logic [CW-1:0] n_rsize;
    logic          n_swap_req;
    logic [CW-1:0] n_swap_size;
    logic [CW-1:0] n_cap;

    logic          ok;
    logic          popped;
    logic          drained;
    logic          n_drained;
    logic [31:0]   cfg_val;

    always_comb begin
        cfg_val = 32'(i_cfg_data);
        if (cfg_val == 32'd0) begin
            n_cap = CW'(1);
        end else if (cfg_val > BANK_DEPTH) begin
            n_cap = CW'(BANK_DEPTH);
        end else begin
            n_cap = CW'(cfg_val);
        end
    end

    always_comb begin
        n_sel       = r_sel;
        n_wc        = r_wc;
        n_rpos      = r_rpos;
        n_rsize     = r_rsize;
        n_swap_req  = r_swap_req;
        n_swap_size = r_swap_size;
        ok          = 1'b0;
        popped      = 1'b0;
        o_wr_en     = 1'b0;
        o_rd_en     = 1'b0;
        o_wr_addr   = {r_sel, r_wc[AW-1:0]};
        o_rd_addr   = {~r_sel, r_rpos[AW-1:0]};
        o_wr_data   = DATA_WIDTH'(i_item.push_data);
        drained     = (r_rpos >= r_rsize);

        if (i_fire) begin
            case (i_item.command)
                pbc_pkg::CMD_PUSH: begin
                    if (!r_swap_req && (r_wc < r_cap)) begin
                        o_wr_en = 1'b1;
                        n_wc    = r_wc + CW'(1);
                        ok      = 1'b1;
                    end
                end
                pbc_pkg::CMD_FLUSH: begin
                    if ((r_wc != '0) && !r_swap_req) begin
                        ok = 1'b1;
                        if (drained) begin
                            n_sel   = ~r_sel;
                            n_rsize = r_wc;
                            n_rpos  = '0;
                            n_wc    = '0;
                        end else begin
                            n_swap_req  = 1'b1;
                            n_swap_size = r_wc;
                        end
                    end
                end
                pbc_pkg::CMD_POP: begin
                    if (!drained) begin
                        o_rd_en = 1'b1;
                        n_rpos  = r_rpos + CW'(1);
                        ok      = 1'b1;
                        popped  = 1'b1;
                    end
                    if (r_swap_req && (n_rpos >= r_rsize)) begin
                        n_sel       = ~r_sel;
                        n_rsize     = r_swap_size;
                        n_rpos      = '0;
                        n_wc        = '0;
                        n_swap_req  = 1'b0;
                        n_swap_size = '0;
                    end
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
        end

        n_drained             = (n_rpos >= n_rsize);
        o_stat.ok             = ok;
        o_stat.popped         = popped;
        o_stat.is_empty       = n_drained && (n_wc == '0);
        o_stat.is_full        = (n_wc >= r_cap);
        o_stat.write_fill     = pbc_pkg::CNT_W'(n_wc);
        o_stat.read_left      = n_drained ? '0 : pbc_pkg::CNT_W'(n_rsize - n_rpos);
        o_stat.swap_pending   = n_swap_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= 1'b0;
            r_wc        <= '0;
            r_rpos      <= '0;
            r_rsize     <= '0;
            r_swap_req  <= 1'b0;
            r_swap_size <= '0;
            r_cap       <= CW'(BANK_DEPTH);
        end else begin
            if (i_fire) begin
                r_sel       <= n_sel;
                r_wc        <= n_wc;
                r_rpos      <= n_rpos;
                r_rsize     <= n_rsize;
                r_swap_req  <= n_swap_req;
                r_swap_size <= n_swap_size;
            end
            if (i_cfg_we) begin
                r_cap <= n_cap;
            end
        end
    end

endmodule

### bench/ping_pong_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ping_pong_checker: status and data predictor for the ping-pong buffer
// Watches the configuration, input and result channels. It keeps its own
// copy of both banks and of the index and swap state. It computes the reply
// to each accepted command and compares every accepted result, field by
// field, with the oldest reply still waiting.
// ----------------------------------------------------------------------------
module ping_pong_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [pbc_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  pbc_pkg::t_in_item         i_in_item,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  pbc_pkg::t_out_item        i_out_item,
    output int                        o_fail_count,
    output int                        o_outstanding
);

    localparam int unsigned DEPTH  = 1024;
    localparam int unsigned ADDR_W = $clog2(DEPTH);

    logic [pbc_pkg::WORD_W-1:0] bank_words [0:2*DEPTH-1];
    logic                       wr_sel;
    logic [pbc_pkg::CNT_W-1:0]  wr_count;
    logic [pbc_pkg::CNT_W-1:0]  rd_pos;
    logic [pbc_pkg::CNT_W-1:0]  rd_size;
    logic                       swap_req;
    logic [pbc_pkg::CNT_W-1:0]  swap_sz;
    logic [pbc_pkg::CNT_W-1:0]  capacity;

    pbc_pkg::t_out_item         buffer_replies_q [$];
    int                         mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    task automatic clear_buffer_state();
        wr_sel   = 1'b0;
        wr_count = '0;
        rd_pos   = '0;
        rd_size  = '0;
        swap_req = 1'b0;
        swap_sz  = '0;
        capacity = pbc_pkg::CNT_W'(DEPTH);
    endtask

    task automatic set_capacity(input logic [pbc_pkg::CFG_W-1:0] value);
        if (value == '0) begin
            capacity = pbc_pkg::CNT_W'(1);
        end else if (value > pbc_pkg::CFG_W'(DEPTH)) begin
            capacity = pbc_pkg::CNT_W'(DEPTH);
        end else begin
            capacity = value;
        end
    endtask

    task automatic swap_banks(input logic [pbc_pkg::CNT_W-1:0] size);
        wr_sel   = ~wr_sel;
        rd_size  = size;
        rd_pos   = '0;
        wr_count = '0;
        swap_req = 1'b0;
        swap_sz  = '0;
    endtask

    task automatic step_buffer(input pbc_pkg::t_in_item item,
                               output pbc_pkg::t_out_item reply);
        logic                       ok;
        logic [pbc_pkg::WORD_W-1:0] word;
        logic                       drained;
        ok   = 1'b0;
        word = '0;
        case (item.command)
            pbc_pkg::CMD_PUSH: begin
                if (!swap_req && wr_count < capacity) begin
                    bank_words[{wr_sel, wr_count[ADDR_W-1:0]}] = item.push_data;
                    wr_count = wr_count + pbc_pkg::CNT_W'(1);
                    ok = 1'b1;
                end
            end
            pbc_pkg::CMD_FLUSH: begin
                if (wr_count != '0 && !swap_req) begin
                    ok = 1'b1;
                    if (rd_pos >= rd_size) begin
                        swap_banks(wr_count);
                    end else begin
                        swap_req = 1'b1;
                        swap_sz  = wr_count;
                    end
                end
            end
            pbc_pkg::CMD_POP: begin
                if (rd_pos < rd_size) begin
                    word   = bank_words[{~wr_sel, rd_pos[ADDR_W-1:0]}];
                    rd_pos = rd_pos + pbc_pkg::CNT_W'(1);
                    ok     = 1'b1;
                end
                if (swap_req && rd_pos >= rd_size) begin
                    swap_banks(swap_sz);
                end
            end
            default: begin
            end
        endcase
        drained              = (rd_pos >= rd_size);
        reply.ok             = ok;
        reply.pop_data       = word;
        reply.is_empty       = drained && (wr_count == '0);
        reply.is_full        = (wr_count >= capacity);
        reply.write_fill     = wr_count;
        reply.read_left      = drained ? '0 : rd_size - rd_pos;
        reply.swap_pending   = swap_req;
    endtask

    task automatic check_field(input string name,
                               input logic [pbc_pkg::WORD_W-1:0] want,
                               input logic [pbc_pkg::WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin
        pbc_pkg::t_out_item want;
        pbc_pkg::t_out_item reply;
        if (!i_rst_n) begin
            clear_buffer_state();
            buffer_replies_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                set_capacity(i_cfg_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (buffer_replies_q.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual %0h",
                             $time, i_out_item);
                    mismatch_total++;
                end else begin
                    want = buffer_replies_q.pop_front();
                    check_field("ok", pbc_pkg::WORD_W'(want.ok),
                                pbc_pkg::WORD_W'(i_out_item.ok));
                    check_field("pop_data", want.pop_data, i_out_item.pop_data);
                    check_field("is_empty", pbc_pkg::WORD_W'(want.is_empty),
                                pbc_pkg::WORD_W'(i_out_item.is_empty));
                    check_field("is_full", pbc_pkg::WORD_W'(want.is_full),
                                pbc_pkg::WORD_W'(i_out_item.is_full));
                    check_field("write_fill", pbc_pkg::WORD_W'(want.write_fill),
                                pbc_pkg::WORD_W'(i_out_item.write_fill));
                    check_field("read_left", pbc_pkg::WORD_W'(want.read_left),
                                pbc_pkg::WORD_W'(i_out_item.read_left));
                    check_field("swap_pending", pbc_pkg::WORD_W'(want.swap_pending),
                                pbc_pkg::WORD_W'(i_out_item.swap_pending));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                step_buffer(i_in_item, reply);
                buffer_replies_q.push_back(reply);
            end
        end
        o_outstanding <= buffer_replies_q.size();
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: ping-pong buffer controller test
// Drives push, flush, pop and unknown commands with random idle bursts on
// both channels and a long result hold-off. Capacity is changed between
// phases while the buffer is quiet. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] CMD_UNKNOWN   = 2'd3;
    localparam int unsigned DEPTH        = 1024;
    localparam int unsigned LONG_HOLD    = 40;
    localparam int unsigned WATCHDOG_MAX = 500;
    localparam int unsigned DRAIN_TAIL   = 6;
    localparam int unsigned PHASE_ITEMS  = 120;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [pbc_pkg::CFG_W-1:0] cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    pbc_pkg::t_in_item         in_item = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    pbc_pkg::t_out_item        out_item;

    logic               idle_enable = 1'b1;
    int unsigned        hold_token = 0;
    int unsigned        items_sent = 0;
    int unsigned        cap_now = DEPTH;
    int unsigned        idle_cycles = 0;
    int                 fail_count;
    int                 outstanding;

    logic [pbc_pkg::CFG_W-1:0] cfg_plan [0:5] =
        '{11'd4, 11'd1, 11'd16, 11'd2047, 11'd2, 11'd1024};

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    ping_pong_buffer_controller_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    ping_pong_checker checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_item    (out_item),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off per token
    initial begin
        int unsigned hold_seen;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end else if (idle_enable && $urandom_range(4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [pbc_pkg::WORD_W-1:0] random_word();
        int unsigned sel;
        sel = $urandom_range(7);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return $urandom;
    endfunction

    task automatic send_cmd(input logic [1:0] cmd,
                            input logic [pbc_pkg::WORD_W-1:0] data);
        if (idle_enable && $urandom_range(3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_item.command   <= cmd;
        in_item.push_data <= data;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_for_replies();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_capacity(input logic [pbc_pkg::CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (value == '0) begin
            cap_now = 1;
        end else if (value > pbc_pkg::CFG_W'(DEPTH)) begin
            cap_now = DEPTH;
        end else begin
            cap_now = 32'(value);
        end
    endtask

    task automatic run_random(input int unsigned quota);
        int unsigned stop_at;
        int unsigned burst;
        int unsigned steps;
        int unsigned pick;
        logic [1:0]  noise_cmd;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            if ($urandom_range(9) < 7) begin
                // fill, flush, then mostly drain with pushes and flushes mixed in
                burst = $urandom_range(1, (cap_now < 20) ? cap_now + 1 : 20);
                repeat (burst) send_cmd(pbc_pkg::CMD_PUSH, random_word());
                send_cmd(pbc_pkg::CMD_FLUSH, random_word());
                steps = $urandom_range(0, 2 * burst + 2);
                repeat (steps) begin
                    pick = $urandom_range(9);
                    if (pick < 6) begin
                        send_cmd(pbc_pkg::CMD_POP, random_word());
                    end else if (pick < 9) begin
                        send_cmd(pbc_pkg::CMD_PUSH, random_word());
                    end else begin
                        send_cmd(pbc_pkg::CMD_FLUSH, random_word());
                    end
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    noise_cmd = 2'($urandom_range(0, 3));
                    send_cmd(noise_cmd, random_word());
                end
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(pbc_pkg::CMD_POP, '0);
        send_cmd(pbc_pkg::CMD_FLUSH, '0);
        send_cmd(CMD_UNKNOWN, '1);
        send_cmd(pbc_pkg::CMD_PUSH, 32'h0000_0000);
        send_cmd(pbc_pkg::CMD_PUSH, 32'hFFFF_FFFF);
        send_cmd(pbc_pkg::CMD_FLUSH, '0);
        send_cmd(pbc_pkg::CMD_PUSH, 32'h5A5A_A5A5);
        send_cmd(pbc_pkg::CMD_FLUSH, '0);
        send_cmd(pbc_pkg::CMD_PUSH, 32'h1234_5678);
        send_cmd(pbc_pkg::CMD_FLUSH, '0);
        send_cmd(pbc_pkg::CMD_POP, '0);
        send_cmd(pbc_pkg::CMD_POP, '0);
        send_cmd(pbc_pkg::CMD_POP, '0);
        send_cmd(pbc_pkg::CMD_POP, '0);
        wait_for_replies();

        write_capacity('0);
        send_cmd(pbc_pkg::CMD_PUSH, 32'hA5A5_5A5A);
        send_cmd(pbc_pkg::CMD_PUSH, 32'h0F0F_F0F0);
        send_cmd(pbc_pkg::CMD_FLUSH, '0);
        send_cmd(pbc_pkg::CMD_POP, '0);
        wait_for_replies();

        // lower capacity under the current write count
        write_capacity(11'd8);
        repeat (4) send_cmd(pbc_pkg::CMD_PUSH, random_word());
        wait_for_replies();
        write_capacity(11'd2);
        send_cmd(pbc_pkg::CMD_PUSH, random_word());
        send_cmd(pbc_pkg::CMD_FLUSH, '0);
        send_cmd(pbc_pkg::CMD_POP, '0);

        for (int p = 0; p < 6; p++) begin
            wait_for_replies();
            write_capacity(cfg_plan[p]);
            if (p == 2) begin
                hold_token <= hold_token + 1;
            end
            if (p == 5) begin
                idle_enable <= 1'b0;
            end
            run_random(PHASE_ITEMS);
        end

        wait_for_replies();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/pbc_pkg.sv
rtl/pbc_bank_mem.sv
rtl/pbc_ctrl.sv
rtl/ping_pong_buffer_controller_unit.sv
bench/ping_pong_checker.sv
bench/testbench.sv
